// File: hw/rtl/assert_macros.svh
// assertion macros used by the top rtl file clothoid_fresnel_point_top.sv
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define CFP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CFP_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hw/rtl/cfp_pkg.sv
// constants, tables and types of the clothoid point block
// no dependencies
`default_nettype none

package cfp_pkg;

    // integration steps, a power of two
    localparam int STEPS_LOG2 = 9;
    localparam int STEPS      = 1 << STEPS_LOG2;

    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [31:0] PI_Q30     = 32'hC90F_DAA2;
    localparam logic [63:0] INV4PI_Q64 = 64'h145F_306D_C9C8_82A5;

    // divider iterations for the phase rate
    localparam int DIV_BITS  = 128;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    // accumulator and output scaling widths
    localparam int SUM_W = 35 + STEPS_LOG2;
    localparam int HI_W  = SUM_W - 32;
    localparam int M_W   = 32 + HI_W + 1;
    localparam int R_W   = M_W - 1 - STEPS_LOG2;

    // horner slots: cos uses all, sin skips the first
    localparam int N_SLOT = 6;
    localparam logic [N_SLOT-1:0] SIN_ON = 6'b111110;
    localparam logic [31:0] COS_DIV [N_SLOT] = '{
        32'd132, 32'd90, 32'd56, 32'd30, 32'd12, 32'd2};
    localparam logic [31:0] SIN_DIV [N_SLOT] = '{
        32'd2, 32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
    localparam logic [31:0] COS_RECIP [N_SLOT] = '{
        32'(64'h1_0000_0000 / 64'd132), 32'(64'h1_0000_0000 / 64'd90),
        32'(64'h1_0000_0000 / 64'd56),  32'(64'h1_0000_0000 / 64'd30),
        32'(64'h1_0000_0000 / 64'd12),  32'(64'h1_0000_0000 / 64'd2)};
    localparam logic [31:0] SIN_RECIP [N_SLOT] = '{
        32'(64'h1_0000_0000 / 64'd2),   32'(64'h1_0000_0000 / 64'd110),
        32'(64'h1_0000_0000 / 64'd72),  32'(64'h1_0000_0000 / 64'd42),
        32'(64'h1_0000_0000 / 64'd20),  32'(64'h1_0000_0000 / 64'd6)};

    // sin/cos pipeline stages: octant, square, three per slot, product, mapping
    localparam int SC_STAGES = 2 + 3 * N_SLOT + 2;

    typedef struct packed {
        logic        valid;
        logic [31:0] station;
        logic [63:0] rate;
    } t_phase_job;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [63:0] phase;
    } t_sc_in;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [33:0] cos_v;
        logic [33:0] sin_v;
    } t_sc_out;

endpackage

`default_nettype wire

// File: hw/rtl/cfp_ifs.sv
// valid/ready channel interfaces of the clothoid point block
// no dependencies
`default_nettype none

interface cfp_station_if;
    logic        valid;
    logic        ready;
    logic [31:0] station;
    modport source (output valid, output station, input ready);
    modport sink   (input valid, input station, output ready);
endinterface

interface cfp_point_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface cfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cfp_phase_rate.sv
// phase rate unit: s^2 * k / a^2 by partial products and a restoring divider
// depends on cfp_pkg
`default_nettype none

module cfp_phase_rate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_station,
    input  logic [31:0]         i_constant,
    input  logic                i_take,
    output logic                o_busy,
    output cfp_pkg::t_phase_job o_job
);
    import cfp_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_SQR  = 5'b00010,
        F_MUL  = 5'b00100,
        F_DIV  = 5'b01000,
        F_HOLD = 5'b10000
    } t_fstate;

    t_fstate              r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [31:0]          r_s, r_a;
    logic [63:0]          r_ss, r_d, r_rem;
    logic [127:0]         r_num;

    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;
    logic [6:0]   w_sh;
    logic [64:0]  w_rem_sh, w_diff;
    logic         w_ge;

    // partial product select: low bit picks the s^2 half, next bit the k half
    assign w_pa = r_cnt[0] ? r_ss[63:32] : r_ss[31:0];
    assign w_pb = r_cnt[1] ? INV4PI_Q64[63:32] : INV4PI_Q64[31:0];
    assign w_pp = 64'(w_pa) * 64'(w_pb);
    assign w_sh = 7'({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]}) << 5;

    assign w_rem_sh = {r_rem, r_num[127]};
    assign w_ge     = w_rem_sh >= {1'b0, r_d};
    assign w_diff   = w_rem_sh - {1'b0, r_d};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_start) n_state = F_SQR;
            F_SQR:  n_state = F_MUL;
            F_MUL:  if (r_cnt[1:0] == 2'd3) n_state = F_DIV;
            F_DIV:  if (r_cnt == DIV_CNT_W'(DIV_BITS - 1)) n_state = F_HOLD;
            F_HOLD: if (i_take) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_s <= i_station;
                r_a <= (i_constant == 32'd0) ? 32'd1 : i_constant;
            end
            F_SQR: begin
                r_ss  <= 64'(r_s) * 64'(r_s);
                r_d   <= 64'(r_a) * 64'(r_a);
                r_num <= '0;
                r_cnt <= '0;
            end
            F_MUL: begin
                r_num <= r_num + ({64'd0, w_pp} << w_sh);
                r_cnt <= (r_cnt[1:0] == 2'd3) ? '0 : r_cnt + 1'b1;
                r_rem <= '0;
            end
            F_DIV: begin
                r_rem <= w_ge ? w_diff[63:0] : w_rem_sh[63:0];
                r_num <= {r_num[126:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            F_HOLD: begin
                r_num <= r_num;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_busy        = r_state != F_IDLE;
    assign o_job.valid   = r_state == F_HOLD;
    assign o_job.station = r_s;
    assign o_job.rate    = r_num[2*STEPS_LOG2 +: 64];

endmodule

`default_nettype wire

// File: hw/rtl/cfp_sincos.sv
// sin/cos pipeline: octant fold, truncated taylor series in horner form
// depends on cfp_pkg
`default_nettype none

module cfp_sincos (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfp_pkg::t_sc_in  i_in,
    output cfp_pkg::t_sc_out o_out
);
    import cfp_pkg::*;

    typedef struct packed {
        logic        last;
        logic [2:0]  oct;
        logic [31:0] x;
        logic [31:0] x2;
        logic [32:0] tc;
        logic [32:0] ts;
        logic [31:0] pc;
        logic [31:0] ps;
        logic [31:0] qc;
        logic [31:0] qs;
    } t_hstage;

    logic [SC_STAGES-1:0] r_vld;

    // octant fold and angle
    logic [31:0] w_f;
    logic [32:0] w_fm;
    logic [64:0] w_xp;
    t_hstage     r_a, r_b, n_a, n_b;
    logic [63:0] w_x2p;

    assign w_f  = i_in.phase[60:29];
    assign w_fm = i_in.phase[61] ? (ONE_Q32 - 33'(w_f)) : 33'(w_f);
    assign w_xp = 65'(w_fm) * 65'(PI_Q30);
    assign w_x2p = 64'(r_a.x) * 64'(r_a.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SC_STAGES-2:0], i_in.valid};
        end
    end

    always_comb begin
        n_a      = '0;
        n_a.last = i_in.last;
        n_a.oct  = i_in.phase[63:61];
        n_a.x    = w_xp[63:32];
        n_b      = r_a;
        n_b.x2   = w_x2p[63:32];
        n_b.tc   = ONE_Q32;
        n_b.ts   = ONE_Q32;
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    t_hstage w_slot [N_SLOT+1];
    t_hstage r_sa [N_SLOT];
    t_hstage r_sb [N_SLOT];
    t_hstage r_sc [N_SLOT];

    assign w_slot[0] = r_b;

    for (genvar j = 0; j < N_SLOT; j++) begin : g_slot
        logic [64:0] w_pc, w_ps;
        logic [63:0] w_qc, w_qs;
        logic [31:0] w_rc, w_rs, w_qcf, w_qsf;
        t_hstage     n_sa, n_sb, n_sc;

        // product with the running term
        assign w_pc = 65'(w_slot[j].x2) * 65'(w_slot[j].tc);
        assign w_ps = 65'(w_slot[j].x2) * 65'(w_slot[j].ts);
        // reciprocal estimate of the quotient, low by at most one
        assign w_qc = 64'(r_sa[j].pc) * 64'(COS_RECIP[j]);
        assign w_qs = 64'(r_sa[j].ps) * 64'(SIN_RECIP[j]);
        // remainder check fixes the estimate
        assign w_rc  = r_sb[j].pc - 32'(r_sb[j].qc * COS_DIV[j]);
        assign w_rs  = r_sb[j].ps - 32'(r_sb[j].qs * SIN_DIV[j]);
        assign w_qcf = r_sb[j].qc + 32'(w_rc >= COS_DIV[j]);
        assign w_qsf = r_sb[j].qs + 32'(w_rs >= SIN_DIV[j]);

        always_comb begin
            n_sa    = w_slot[j];
            n_sa.pc = w_pc[63:32];
            n_sa.ps = w_ps[63:32];
            n_sb    = r_sa[j];
            n_sb.qc = w_qc[63:32];
            n_sb.qs = w_qs[63:32];
            n_sc    = r_sb[j];
            n_sc.tc = ONE_Q32 - 33'(w_qcf);
            if (SIN_ON[j]) begin
                n_sc.ts = ONE_Q32 - 33'(w_qsf);
            end
        end

        always_ff @(posedge i_clk) begin
            r_sa[j] <= n_sa;
            r_sb[j] <= n_sb;
            r_sc[j] <= n_sc;
        end

        assign w_slot[j+1] = r_sc[j];
    end

    // final sin product, then octant mapping
    t_hstage     w_end;
    logic [64:0] w_sp;
    logic        r_f_last, r_g_last;
    logic [2:0]  r_f_oct;
    logic [31:0] r_f_s;
    logic [32:0] r_f_c;
    logic [33:0] w_sa, w_ca, r_g_cos, r_g_sin;

    assign w_end = w_slot[N_SLOT];
    assign w_sp  = 65'(w_end.x) * 65'(w_end.ts);
    assign w_sa  = r_f_oct[0] ? 34'(r_f_c) : 34'(r_f_s);
    assign w_ca  = r_f_oct[0] ? 34'(r_f_s) : 34'(r_f_c);

    always_ff @(posedge i_clk) begin
        r_f_last <= w_end.last;
        r_f_oct  <= w_end.oct;
        r_f_s    <= w_sp[63:32];
        r_f_c    <= w_end.tc;
        r_g_last <= r_f_last;
        unique case (r_f_oct[2:1])
            2'd0: begin r_g_cos <= w_ca;       r_g_sin <= w_sa;       end
            2'd1: begin r_g_cos <= -w_sa;      r_g_sin <= w_ca;       end
            2'd2: begin r_g_cos <= -w_ca;      r_g_sin <= -w_sa;      end
            default: begin r_g_cos <= w_sa;    r_g_sin <= -w_ca;      end
        endcase
    end

    assign o_out.valid = r_vld[SC_STAGES-1];
    assign o_out.last  = r_g_last;
    assign o_out.cos_v = r_g_cos;
    assign o_out.sin_v = r_g_sin;

endmodule

`default_nettype wire

// File: hw/rtl/clothoid_fresnel_point_top.sv
// stations are limited by the single sin/cos pipeline, which takes one phase per cycle
//   and drains before the next station starts; the phase-rate divider works on the
//   next station meanwhile
// reset: synchronous active low, clears handshake state, constant back to 1.0
`default_nettype none
`include "assert_macros.svh"

module clothoid_fresnel_point_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cfp_station_if.sink  i_station,
    cfp_point_if.source  o_point,
    cfp_cfg_if.sink      i_cfg
);
    import cfp_pkg::*;

    // integrator sequencer
    typedef enum logic [3:0] {
        I_IDLE  = 4'b0001,
        I_ISSUE = 4'b0010,
        I_DRAIN = 4'b0100,
        I_DONE  = 4'b1000
    } t_istate;

    logic [31:0] r_const;

    // config register, always ready
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const <= 32'h0001_0000;
        end else if (i_cfg.valid) begin
            r_const <= i_cfg.data;
        end
    end

    // front end: phase rate per station
    t_phase_job w_job;
    logic       w_front_busy, w_job_take;

    assign i_station.ready = !w_front_busy;

    cfp_phase_rate u_rate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_station.valid),
        .i_station  (i_station.station),
        .i_constant (r_const),
        .i_take     (w_job_take),
        .o_busy     (w_front_busy),
        .o_job      (w_job)
    );

    t_istate             r_state, n_state;
    logic [63:0]         r_rate, r_p, r_dl;
    logic [31:0]         r_s;
    logic [STEPS_LOG2:0] r_cnt;
    logic                w_issue_last, w_sc_take;
    t_sc_in              w_sc_in;
    t_sc_out             w_sc_out;

    assign w_job_take   = (r_state == I_IDLE) && w_job.valid;
    assign w_issue_last = r_cnt == (STEPS_LOG2 + 1)'(STEPS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            I_IDLE:  if (w_job.valid) n_state = I_ISSUE;
            I_ISSUE: if (w_issue_last) n_state = I_DRAIN;
            I_DRAIN: if (w_sc_out.valid && w_sc_out.last) n_state = I_DONE;
            I_DONE:  if (w_sc_take) n_state = I_IDLE;
            default: n_state = I_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= I_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // phase i^2*t by second differences: p += d, d += 2t
    always_ff @(posedge i_clk) begin
        if (w_job_take) begin
            r_rate <= w_job.rate;
            r_s    <= w_job.station;
            r_p    <= w_job.rate;
            r_dl   <= w_job.rate + {w_job.rate[62:0], 1'b0};
            r_cnt  <= (STEPS_LOG2 + 1)'(1);
        end else if (r_state == I_ISSUE) begin
            r_p   <= r_p + r_dl;
            r_dl  <= r_dl + {r_rate[62:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign w_sc_in.valid = r_state == I_ISSUE;
    assign w_sc_in.last  = w_issue_last;
    assign w_sc_in.phase = r_p;

    cfp_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (w_sc_in),
        .o_out   (w_sc_out)
    );

    // trapezoid sums, doubled: inner terms count twice, the end term once, plus one on x only
    logic [SUM_W-1:0] r_sum_x, r_sum_y, w_cext, w_sext, w_term_x, w_term_y;

    assign w_cext   = {{(SUM_W-34){w_sc_out.cos_v[33]}}, w_sc_out.cos_v};
    assign w_sext   = {{(SUM_W-34){w_sc_out.sin_v[33]}}, w_sc_out.sin_v};
    assign w_term_x = w_sc_out.last ? (SUM_W'(ONE_Q32) + w_cext) : {w_cext[SUM_W-2:0], 1'b0};
    assign w_term_y = w_sc_out.last ? w_sext : {w_sext[SUM_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_job_take) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (w_sc_out.valid) begin
            r_sum_x <= r_sum_x + w_term_x;
            r_sum_y <= r_sum_y + w_term_y;
        end
    end

    // output scaling, stage one: s times the sum in two partial products
    logic                r_sc_valid, r_out_valid, w_out_load;
    logic                r_pos_x, r_pos_y;
    logic [32+HI_W-1:0]  r_mh_x, r_mh_y;
    logic [31:0]         r_ml_x, r_ml_y;
    logic [63:0]         w_ml_x, w_ml_y;

    assign w_out_load = r_sc_valid && (!r_out_valid || o_point.ready);
    assign w_sc_take  = (r_state == I_DONE) && (!r_sc_valid || w_out_load);
    assign w_ml_x     = 64'(r_s) * 64'(r_sum_x[31:0]);
    assign w_ml_y     = 64'(r_s) * 64'(r_sum_y[31:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid <= 1'b0;
        end else if (w_sc_take) begin
            r_sc_valid <= 1'b1;
        end else if (w_out_load) begin
            r_sc_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sc_take) begin
            r_pos_x <= !r_sum_x[SUM_W-1] && (r_sum_x != '0);
            r_pos_y <= !r_sum_y[SUM_W-1] && (r_sum_y != '0);
            r_mh_x  <= (32+HI_W)'(r_s) * (32+HI_W)'(r_sum_x[SUM_W-1:32]);
            r_mh_y  <= (32+HI_W)'(r_s) * (32+HI_W)'(r_sum_y[SUM_W-1:32]);
            r_ml_x  <= w_ml_x[63:32];
            r_ml_y  <= w_ml_y[63:32];
        end
    end

    // stage two: add, divide by 2*STEPS, clamp, into the output register
    logic [M_W-1:0] w_m_x, w_m_y;
    logic [R_W-1:0] w_r_x, w_r_y;
    logic [31:0]    r_out_x, r_out_y;

    assign w_m_x = M_W'(r_mh_x) + M_W'(r_ml_x);
    assign w_m_y = M_W'(r_mh_y) + M_W'(r_ml_y);
    assign w_r_x = w_m_x[M_W-1:STEPS_LOG2+1];
    assign w_r_y = w_m_y[M_W-1:STEPS_LOG2+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            // non-positive sum gives zero, overflow saturates
            r_out_x <= !r_pos_x ? 32'd0 : (|w_r_x[R_W-1:32]) ? 32'hFFFF_FFFF : w_r_x[31:0];
            r_out_y <= !r_pos_y ? 32'd0 : (|w_r_y[R_W-1:32]) ? 32'hFFFF_FFFF : w_r_y[31:0];
        end
    end

    assign o_point.valid   = r_out_valid;
    assign o_point.point_x = r_out_x;
    assign o_point.point_y = r_out_y;

    // finished sums stay until the scaler takes them
    `CFP_ASSERT(a_done_holds, i_clk, i_rst_n, r_state == I_DONE |=> r_state == I_DONE || r_state == I_IDLE, "sums left before handoff")
    // sin/cos results only while a station is being integrated
    `CFP_ASSERT(a_sc_in_window, i_clk, i_rst_n, w_sc_out.valid |-> r_state == I_ISSUE || r_state == I_DRAIN, "stray sin/cos result")
    // end term arrives only after the last phase was issued
    `CFP_NEVER(a_last_early, i_clk, i_rst_n, w_sc_out.valid && w_sc_out.last && r_state != I_DRAIN, "end term out of order")

endmodule

`default_nettype wire

// File: test/clothoid_fresnel_point_top_test.sv
// testbench of clothoid_fresnel_point_top: bit-exact point prediction and checking
// depends on cfp_pkg, the channel interfaces in cfp_ifs.sv and the block itself
`timescale 1ns / 100ps

module clothoid_fresnel_point_top_test;
    import cfp_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
    } point_t;

    logic clk;
    logic rst_n;

    cfp_station_if station_ch ();
    cfp_point_if   point_ch ();
    cfp_cfg_if     cfg_ch ();

    clothoid_fresnel_point_top uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_station (station_ch.sink),
        .o_point   (point_ch.source),
        .i_cfg     (cfg_ch.sink)
    );

    // clothoid constant as the block should hold it
    logic [31:0] model_constant;
    // points still owed by the block, oldest first
    point_t      pending_points[$];
    int          mismatch_count;
    // idling on both sides, off for the final phase
    bit          idle_on;
    // long receiver hold-off, length counted by the receiver process
    bit          hold_req;
    int          hold_cycles;

    // clock, 10 ns period
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #50ms;
        $display("FAIL clothoid_fresnel_point_top");
        $finish;
    end

    // sin and cos of one phase (fraction of a turn), doubled-free q32 values
    function automatic void phase_sin_cos(input longint unsigned phase,
                                          output longint signed cv,
                                          output longint signed sv);
        longint unsigned oct, f, x, x2, ts, tc, s, c, sa, ca, k;
        oct = phase >> 61;
        f   = (phase >> 29) & 64'hFFFF_FFFF;
        // odd octants mirror the fraction
        if (oct[0]) begin
            f = 64'h1_0000_0000 - f;
        end
        x  = (f * 64'(PI_Q30)) >> 32;
        x2 = (x * x) >> 32;
        ts = 64'h1_0000_0000;
        tc = 64'h1_0000_0000;
        for (k = 11; k >= 3; k -= 2) begin
            ts = 64'h1_0000_0000 - ((x2 * ts) >> 32) / (k * (k - 1));
        end
        for (k = 12; k >= 2; k -= 2) begin
            tc = 64'h1_0000_0000 - ((x2 * tc) >> 32) / (k * (k - 1));
        end
        s = (x * ts) >> 32;
        c = tc;
        if (oct[0]) begin
            sa = c;
            ca = s;
        end else begin
            sa = s;
            ca = c;
        end
        case (oct >> 1)
            0: begin cv = ca;  sv = sa;  end
            1: begin cv = -sa; sv = ca;  end
            2: begin cv = -ca; sv = -sa; end
            default: begin cv = sa; sv = -ca; end
        endcase
    endfunction

    // doubled sum scaled by s/STEPS, clamped to zero and to the largest q16.16
    function automatic logic [31:0] scale_coord(input logic [31:0] s, input longint signed sum2);
        longint unsigned u, m, r, sw;
        if (sum2 <= 0) begin
            return 32'd0;
        end
        u  = sum2;
        sw = s;
        m  = sw * (u >> 32) + ((sw * (u & 64'hFFFF_FFFF)) >> 32);
        r  = (m >> 1) / STEPS;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic point_t clothoid_point(input logic [31:0] s, input logic [31:0] a_raw);
        logic [127:0]    num;
        logic [63:0]     a, rate;
        longint unsigned i;
        longint signed   sx2, sy2, c, sn;
        point_t          p;
        // zero constant counts as the smallest step
        a    = (a_raw == 32'd0) ? 64'd1 : 64'(a_raw);
        num  = 128'(64'(s) * 64'(s)) * 128'(INV4PI_Q64);
        num  = num / 128'(a * a);
        num  = num / 128'(STEPS * STEPS);
        rate = num[63:0];
        sx2  = 0;
        sy2  = 0;
        for (i = 1; i < STEPS; i++) begin
            phase_sin_cos(i * i * rate, c, sn);
            sx2 += c * 2;
            sy2 += sn * 2;
        end
        i = STEPS;
        phase_sin_cos(i * i * rate, c, sn);
        sx2 += 64'sh1_0000_0000 + c;
        sy2 += sn;
        p.x = scale_coord(s, sx2);
        p.y = scale_coord(s, sy2);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // receiver: random stalls, plus the long hold-off on request
    initial begin
        point_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                point_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                point_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            point_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // check every point transaction against the oldest prediction
    always @(posedge clk) begin
        point_t want;
        if (rst_n && point_ch.valid && point_ch.ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected point", point_ch.point_x, 32'd0);
            end else begin
                want = pending_points.pop_front();
                if (point_ch.point_x !== want.x) report_mismatch("x", point_ch.point_x, want.x);
                if (point_ch.point_y !== want.y) report_mismatch("y", point_ch.point_y, want.y);
            end
        end
    end

    // offer one station; valid stays high until a gap or a drain lowers it
    task automatic send_station(input logic [31:0] s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            station_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        station_ch.valid   <= 1'b1;
        station_ch.station <= s;
        do @(posedge clk); while (!station_ch.ready);
        pending_points.push_back(clothoid_point(s, model_constant));
    endtask

    // sender stops and waits for every owed point, then for the pipeline tail
    task automatic drain_points();
        station_ch.valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    // constant written only with the block idle
    task automatic write_constant(input logic [31:0] value);
        drain_points();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid   <= 1'b0;
        model_constant = value;
    endtask

    // mix of full range, short arcs and arcs with random bit patterns
    function automatic logic [31:0] random_station();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000);
            2: return $urandom >> $urandom_range(0, 31);
            default: return $urandom & $urandom;
        endcase
    endfunction

    task automatic test_default_constant();
        logic [31:0] corners[$] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000,
                                    32'h8000_0000, 32'h0002_8000, 32'h0005_0000,
                                    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (corners[k]) send_station(corners[k]);
    endtask

    task automatic test_constant_extremes();
        logic [31:0] consts[$]   = '{32'h0, 32'h1, 32'hFFFF_FFFF};
        logic [31:0] stations[$] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100};
        foreach (consts[k]) begin
            write_constant(consts[k]);
            foreach (stations[j]) send_station(stations[j]);
        end
    endtask

    // block fills and stalls its input while the receiver holds off
    task automatic test_output_hold();
        write_constant(32'h0001_0000);
        hold_cycles = 3000;
        hold_req    = 1'b1;
        repeat (6) send_station(random_station());
        drain_points();
    endtask

    task automatic test_random(input logic [31:0] cnst, input int count);
        write_constant(cnst);
        repeat (count) send_station(random_station());
    endtask

    initial begin
        rst_n              <= 1'b0;
        station_ch.valid   <= 1'b0;
        station_ch.station <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= '0;
        model_constant     = 32'h0001_0000;
        mismatch_count     = 0;
        idle_on            = 1'b1;
        hold_req           = 1'b0;
        hold_cycles        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_constant();
        test_constant_extremes();
        test_output_hold();
        test_random(32'h0001_0000, 190);
        test_random(32'h0000_8000, 190);
        test_random(32'h0002_0000, 190);
        test_random($urandom, 190);
        test_random(32'h0000_0000, 60);
        test_random(32'hFFFF_FFFF, 100);
        // final stretch runs without idling
        drain_points();
        idle_on = 1'b0;
        test_random($urandom_range(1, 32'h0010_0000), 200);

        drain_points();
        if (mismatch_count == 0) begin
            $display("PASS clothoid_fresnel_point_top");
        end else begin
            $display("FAIL clothoid_fresnel_point_top");
        end
        $finish;
    end

endmodule
